// ----- rtl/alu16_with_nzcv_flags_macros.svh -----
// Assertion macros for the 16-bit ALU with NZCV flags.
// Included by the top level; it depends on nothing else.
`ifndef ALU16_WITH_NZCV_FLAGS_MACROS_SVH
`define ALU16_WITH_NZCV_FLAGS_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ALU16_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("ALU16 same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define ALU16_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("ALU16 next-cycle check failed");
`else
`define ALU16_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define ALU16_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ----- rtl/alu16_pkg.sv -----
// Package for the 16-bit ALU: word width, operation codes and the flag bundle.
// Used by alu16_core and the top level; it depends on nothing.
package alu16_pkg;

  localparam int unsigned WordBits  = 16;
  localparam int unsigned ShAmtBits = 5;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_CMP = 3'd2,
    OP_AND = 3'd3,
    OP_OR  = 3'd4,
    OP_XOR = 3'd5,
    OP_SHL = 3'd6,
    OP_SHR = 3'd7
  } action_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } alu_flags_t;

endpackage

// ----- rtl/alu16_core.sv -----
// Combinational datapath of the 16-bit ALU: result value and NZCV flags.
// Depends on alu16_pkg for the operation codes and the flag bundle.
module alu16_core
  import alu16_pkg::*;
(
  input  action_t    op,
  input  word_t      a,
  input  word_t      b,
  output word_t      result,
  output alu_flags_t flags
);

  logic [WordBits:0]   sum_w;
  logic [WordBits:0]   diff_w;
  logic [WordBits:0]   shl_w;
  logic [WordBits:0]   shr_w;
  logic                sh_big;
  logic [ShAmtBits-1:0] sh_amt;
  word_t               flag_src;
  logic                add_v;
  logic                sub_v;

  assign sum_w  = {1'b0, a} + {1'b0, b};
  assign diff_w = {1'b0, a} - {1'b0, b};

  // Amounts above sixteen clear both the value and the carry.
  assign sh_big = (|b[WordBits-1:ShAmtBits]) ||
                  (b[ShAmtBits-1] && (|b[ShAmtBits-2:0]));
  assign sh_amt = b[ShAmtBits-1:0];
  // The extra bit above (left) or below (right) catches the last bit shifted out.
  assign shl_w  = {1'b0, a} << sh_amt;
  assign shr_w  = {a, 1'b0} >> sh_amt;

  assign add_v = (a[WordBits-1] == b[WordBits-1]) &&
                 (a[WordBits-1] != sum_w[WordBits-1]);
  assign sub_v = (a[WordBits-1] != b[WordBits-1]) &&
                 (a[WordBits-1] != diff_w[WordBits-1]);

  always_comb begin
    result   = '0;
    flag_src = '0;
    flags.c  = 1'b0;
    flags.v  = 1'b0;
    unique case (op) inside
      OP_ADD: begin
        result   = sum_w[WordBits-1:0];
        flag_src = sum_w[WordBits-1:0];
        flags.c  = sum_w[WordBits];
        flags.v  = add_v;
      end
      OP_SUB, OP_CMP: begin
        result   = (op == OP_CMP) ? a : diff_w[WordBits-1:0];
        flag_src = diff_w[WordBits-1:0];
        flags.c  = diff_w[WordBits];
        flags.v  = sub_v;
      end
      OP_AND: begin
        result   = a & b;
        flag_src = a & b;
      end
      OP_OR: begin
        result   = a | b;
        flag_src = a | b;
      end
      OP_XOR: begin
        result   = a ^ b;
        flag_src = a ^ b;
      end
      OP_SHL: begin
        result   = sh_big ? '0 : shl_w[WordBits-1:0];
        flag_src = result;
        flags.c  = sh_big ? 1'b0 : shl_w[WordBits];
      end
      OP_SHR: begin
        result   = sh_big ? '0 : shr_w[WordBits:1];
        flag_src = result;
        flags.c  = sh_big ? 1'b0 : shr_w[0];
      end
      default: begin
        result   = '0;
        flag_src = '0;
      end
    endcase
    flags.z = (flag_src == '0);
    flags.n = flag_src[WordBits-1];
  end

endmodule

// ----- rtl/alu16_with_nzcv_flags.sv -----
// Top level of the 16-bit ALU with NZCV flags; operands are registered, then one pass.
// Operands are captured in the operand stage; result, flags and out_strobe in the result stage.
// Throughput: one transaction per cycle; busy is never raised and nothing stalls.
// The rate is held by the adder, subtractor, shifters and flag logic between the two registers.
// Reset (rst_n low, synchronous) clears both valid stages; no result is lost or invented.
// Depends on alu16_pkg, alu16_core and alu16_with_nzcv_flags_macros.svh.
`include "alu16_with_nzcv_flags_macros.svh"

module alu16_with_nzcv_flags
  import alu16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_a_operand,
  input  logic [15:0] in_b_operand,
  output logic        out_strobe,
  output logic [15:0] out_alu_result,
  output logic        out_zero_flag,
  output logic        out_negative_flag,
  output logic        out_carry_flag,
  output logic        out_overflow_flag
);

  // The datapath is a single combinational pass and the receiver cannot hold results off,
  // so the block is always ready for the next transaction.
  logic accept;

  // Operand stage. Only the valid bit needs a reset.
  logic    in_valid_r;
  action_t op_r;
  word_t   a_r;
  word_t   b_r;

  // Result stage.
  logic       out_strobe_r;
  word_t      result_r;
  alu_flags_t flags_r;

  word_t      result_nxt;
  alu_flags_t flags_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
    if (accept) begin
      op_r <= action_t'(in_action);
      a_r  <= in_a_operand;
      b_r  <= in_b_operand;
    end
  end

  // The whole operation is evaluated in a single combinational pass.
  alu16_core u_core (
    .op     (op_r),
    .a      (a_r),
    .b      (b_r),
    .result (result_nxt),
    .flags  (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_valid_r;
    end
    if (in_valid_r) begin
      result_r <= result_nxt;
      flags_r  <= flags_nxt;
    end
  end

  // Each result is presented for exactly one cycle, as marked by the strobe.
  assign out_strobe        = out_strobe_r;
  assign out_alu_result    = result_r;
  assign out_zero_flag     = flags_r.z;
  assign out_negative_flag = flags_r.n;
  assign out_carry_flag    = flags_r.c;
  assign out_overflow_flag = flags_r.v;

  // Every accepted transaction reaches the operand stage, then the result stage.
  `ALU16_ASSERT_NEXT(a_accept_to_stage, clk, rst_n, accept, in_valid_r)
  `ALU16_ASSERT_NEXT(a_stage_to_strobe, clk, rst_n, in_valid_r, out_strobe)
  // Logic operations never leave carry or overflow set.
  `ALU16_ASSERT_NEXT(a_logic_clears_cv, clk, rst_n,
    in_valid_r && (op_r == OP_AND || op_r == OP_OR || op_r == OP_XOR),
    !out_carry_flag && !out_overflow_flag)
  // Outside compare, zero and negative describe the value that is returned.
  `ALU16_ASSERT_NEXT(a_nz_match_value, clk, rst_n, in_valid_r && op_r != OP_CMP,
    out_zero_flag == (out_alu_result == 16'h0000) &&
    out_negative_flag == out_alu_result[15])

endmodule
